// ===== rtl/flc_pkg.sv =====
// Shared constants, types and codes for the full linear convolution block.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
package flc_pkg;

  localparam int MAX_TAPS        = 16;
  localparam int SAMPLE_WIDTH    = 16;
  localparam int TAP_INDEX_WIDTH = 4;
  localparam int TAP_COUNT_WIDTH = 5;
  localparam int RESULT_WIDTH    = 36;
  localparam int PROD_WIDTH      = 2 * SAMPLE_WIDTH;

  localparam int TREE_LEVELS = $clog2(MAX_TAPS);
  localparam int TREE_LEAVES = 1 << TREE_LEVELS;
  localparam int TAPS_WIDTH  = $clog2(MAX_TAPS + 1);
  localparam int WAIT_WIDTH  = $clog2(TREE_LEVELS + 1);

  localparam int IN_TDATA_WIDTH  = ((TAP_INDEX_WIDTH + SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_WIDTH = ((RESULT_WIDTH + 7) / 8) * 8;

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_SAMPLE = 1'b1
  } flc_action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_OUT
  } flc_state_e;

  // Controls broadcast to every cell of the chain.
  typedef struct packed {
    logic                           shift;
    logic                           clear;
    logic                           tap_load;
    logic signed [SAMPLE_WIDTH-1:0] tap_value;
  } flc_cell_ctrl_t;

endpackage

// ===== rtl/flc_cell.sv =====
// One tap cell of the convolution chain: coefficient, delayed sample, product.
// Depends on flc_pkg for widths and the broadcast control struct.
module flc_cell (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  flc_pkg::flc_cell_ctrl_t                ctrl_i,
  input  logic                                   tap_sel_i,
  input  logic                                   use_i,
  input  logic signed [flc_pkg::SAMPLE_WIDTH-1:0] samp_i,
  output logic signed [flc_pkg::SAMPLE_WIDTH-1:0] samp_o,
  output logic signed [flc_pkg::PROD_WIDTH-1:0]   prod_o
);

  logic signed [flc_pkg::SAMPLE_WIDTH-1:0] tap_q;
  logic signed [flc_pkg::SAMPLE_WIDTH-1:0] samp_q;
  logic signed [flc_pkg::PROD_WIDTH-1:0]   prod_d;
  logic signed [flc_pkg::PROD_WIDTH-1:0]   prod_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.tap_load && tap_sel_i) begin
      tap_q <= ctrl_i.tap_value;
    end
  end

  // The delayed sample moves one cell down the chain on every shift.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samp_q <= '0;
    end else if (ctrl_i.clear) begin
      samp_q <= '0;
    end else if (ctrl_i.shift) begin
      samp_q <= samp_i;
    end
  end

  // Cells beyond the active tap count contribute nothing to the sum.
  always_comb begin
    if (use_i) begin
      prod_d = flc_pkg::PROD_WIDTH'(tap_q) * flc_pkg::PROD_WIDTH'(samp_q);
    end else begin
      prod_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign samp_o = samp_q;
  assign prod_o = prod_q;

endmodule

// ===== rtl/flc_sum_tree.sv =====
// Registered binary adder tree that sums the cell products.
// Depends on flc_pkg; nodes are kept in heap order, node 1 being the root.
module flc_sum_tree (
  input  logic                                    clk_i,
  input  logic signed [flc_pkg::RESULT_WIDTH-1:0] leaf_i [flc_pkg::TREE_LEAVES],
  output logic signed [flc_pkg::RESULT_WIDTH-1:0] root_o
);

  localparam int Leaves = flc_pkg::TREE_LEAVES;

  logic signed [flc_pkg::RESULT_WIDTH-1:0] node_q [1:Leaves-1];

  for (genvar i = 1; i < Leaves; i++) begin : g_node
    if (2 * i >= Leaves) begin : g_bottom
      always_ff @(posedge clk_i) begin
        node_q[i] <= leaf_i[2 * i - Leaves] + leaf_i[2 * i + 1 - Leaves];
      end
    end else begin : g_inner
      always_ff @(posedge clk_i) begin
        node_q[i] <= node_q[2 * i] + node_q[2 * i + 1];
      end
    end
  end

  assign root_o = node_q[1];

endmodule

// ===== rtl/full_linear_convolution.sv =====
// Top level of the full linear convolution block: control, tap chain, output.
// Depends on flc_pkg, flc_cell and flc_sum_tree.
//
// Usage. Kernel taps are written over the slave stream with tuser = 0: tdata
// carries the tap index in bits 3:0 and the Q1.15 coefficient in bits 19:4.
// Signal samples follow with tuser = 1, the sample in tdata bits 19:4; tlast
// marks the final sample of a signal. The number of taps in use is written on
// the cfg channel (reset value 1) and may only change while the block is idle.
// Every sample gives one beat on the master stream with the exact 36-bit sum
// in tdata; the last sample also gives taps-in-use minus one tail beats, and tlast
// is set on the final beat of the signal. The history is then cleared.
// Timing. An accepted sample is shifted into the chain, multiplied into the product
// register in each cell, summed by the four-level registered adder tree and then
// loaded into the output register; the next sample is taken only after its result,
// and any tail beats, have been loaded. Tap loads are taken while the block is idle.
// Reset clears the sample history, the control state and the output valid flag;
// the tap table holds garbage until written. When the receiver stalls the
// result waits in the output register; the next sample can still be taken,
// but its own result is held back until the register is free.
module full_linear_convolution (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Slave stream: tdata = {pad, value[15:0], tap_index[3:0]} from the lowest
  // bit up; tuser = action; tlast = last_sample.
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [flc_pkg::IN_TDATA_WIDTH-1:0]     s_axis_tdata,
  input  logic                                   s_axis_tuser,
  input  logic                                   s_axis_tlast,
  // Master stream: tdata = {pad, result[35:0]} from the lowest bit up;
  // tlast = last_result.
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [flc_pkg::OUT_TDATA_WIDTH-1:0]    m_axis_tdata,
  output logic                                   m_axis_tlast,
  // Configuration channel: tap_count.
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [flc_pkg::TAP_COUNT_WIDTH-1:0]    cfg_data_i
);

  localparam int Taps = flc_pkg::MAX_TAPS;
  localparam int Sw   = flc_pkg::SAMPLE_WIDTH;
  localparam int Rw   = flc_pkg::RESULT_WIDTH;

  // Input beat fields.
  logic [flc_pkg::TAP_INDEX_WIDTH-1:0] in_tap_index;
  logic signed [Sw-1:0]                in_value;
  flc_pkg::flc_action_e                in_action;

  assign in_tap_index = s_axis_tdata[flc_pkg::TAP_INDEX_WIDTH-1:0];
  assign in_value     = s_axis_tdata[flc_pkg::TAP_INDEX_WIDTH +: Sw];
  assign in_action    = flc_pkg::flc_action_e'(s_axis_tuser);

  // Tap count register and its saturated form.
  logic [flc_pkg::TAP_COUNT_WIDTH-1:0] tap_count_q;
  logic [flc_pkg::TAPS_WIDTH-1:0]      taps;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= flc_pkg::TAP_COUNT_WIDTH'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      tap_count_q <= cfg_data_i;
    end
  end

  // A count of zero acts as one tap, and counts above the chain length clip.
  always_comb begin
    if (tap_count_q == '0) begin
      taps = flc_pkg::TAPS_WIDTH'(1);
    end else if (32'(tap_count_q) > Taps) begin
      taps = flc_pkg::TAPS_WIDTH'(Taps);
    end else begin
      taps = flc_pkg::TAPS_WIDTH'(tap_count_q);
    end
  end

  // Sequencer state.
  flc_pkg::flc_state_e               state_q, state_d;
  logic [flc_pkg::WAIT_WIDTH-1:0]    wait_q, wait_d;
  logic [flc_pkg::TAPS_WIDTH-1:0]    tail_q, tail_d;
  logic                              last_q, last_d;
  logic                              out_load;
  flc_pkg::flc_cell_ctrl_t           cell_ctrl;
  logic signed [Sw-1:0]              head_samp;

  // Output register.
  logic                              out_valid_q;
  logic signed [Rw-1:0]              out_data_q;
  logic                              out_last_q;
  logic signed [Rw-1:0]              root;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= flc_pkg::ST_IDLE;
      wait_q  <= '0;
      tail_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
      tail_q  <= tail_d;
      last_q  <= last_d;
    end
  end

  // Each result is made by one shift of the chain, a wait while the products
  // and the adder tree settle, and a hand-off to the output register. Tail
  // results repeat the cycle with a zero shifted in at the head.
  always_comb begin
    state_d             = state_q;
    wait_d              = wait_q;
    tail_d              = tail_q;
    last_d              = last_q;
    s_axis_tready       = 1'b0;
    out_load            = 1'b0;
    head_samp           = in_value;
    cell_ctrl.shift     = 1'b0;
    cell_ctrl.clear     = 1'b0;
    cell_ctrl.tap_load  = 1'b0;
    cell_ctrl.tap_value = in_value;
    unique case (state_q)
      flc_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (in_action == flc_pkg::ACT_SAMPLE) begin
            cell_ctrl.shift = 1'b1;
            last_d          = s_axis_tlast;
            tail_d          = s_axis_tlast ? taps - flc_pkg::TAPS_WIDTH'(1) : '0;
            wait_d          = flc_pkg::WAIT_WIDTH'(flc_pkg::TREE_LEVELS);
            state_d         = flc_pkg::ST_WAIT;
          end else begin
            cell_ctrl.tap_load = 1'b1;
          end
        end
      end
      flc_pkg::ST_WAIT: begin
        if (wait_q == '0) begin
          state_d = flc_pkg::ST_OUT;
        end else begin
          wait_d = wait_q - flc_pkg::WAIT_WIDTH'(1);
        end
      end
      flc_pkg::ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          if (tail_q != '0) begin
            cell_ctrl.shift = 1'b1;
            head_samp       = '0;
            tail_d          = tail_q - flc_pkg::TAPS_WIDTH'(1);
            wait_d          = flc_pkg::WAIT_WIDTH'(flc_pkg::TREE_LEVELS);
            state_d         = flc_pkg::ST_WAIT;
          end else begin
            // End of a signal: wipe the history for the next one.
            cell_ctrl.clear = last_q;
            last_d          = 1'b0;
            state_d         = flc_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = flc_pkg::ST_IDLE;
      end
    endcase
  end

  // Tap chain. Cell k holds tap k and the sample k steps back.
  logic signed [Sw-1:0]                      samp_w [Taps];
  logic signed [flc_pkg::PROD_WIDTH-1:0]     prod_w [Taps];
  logic signed [Rw-1:0]                      leaf_w [flc_pkg::TREE_LEAVES];

  for (genvar k = 0; k < Taps; k++) begin : g_cell
    logic                 tap_sel;
    logic                 use_tap;
    logic signed [Sw-1:0] samp_in;

    assign tap_sel = (32'(in_tap_index) == k);
    assign use_tap = (32'(taps) > k);

    if (k == 0) begin : g_head
      assign samp_in = head_samp;
    end else begin : g_body
      assign samp_in = samp_w[k-1];
    end

    flc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (cell_ctrl),
      .tap_sel_i (tap_sel),
      .use_i     (use_tap),
      .samp_i    (samp_in),
      .samp_o    (samp_w[k]),
      .prod_o    (prod_w[k])
    );
  end

  for (genvar j = 0; j < flc_pkg::TREE_LEAVES; j++) begin : g_leaf
    if (j < Taps) begin : g_used
      assign leaf_w[j] = Rw'(prod_w[j]);
    end else begin : g_pad
      assign leaf_w[j] = '0;
    end
  end

  flc_sum_tree u_sum_tree (
    .clk_i  (clk_i),
    .leaf_i (leaf_w),
    .root_o (root)
  );

  // Output register: refilled only when empty or being drained this cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= root;
      out_last_q <= last_q && (tail_q == '0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(flc_pkg::OUT_TDATA_WIDTH - Rw){1'b0}}, out_data_q};
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready))
    else $error("output register loaded while a beat is still pending");

  a_tail_needs_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_q != '0) |-> last_q)
    else $error("tail results pending without a last sample");

  a_sample_starts_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && in_action == flc_pkg::ACT_SAMPLE)
      |=> (state_q == flc_pkg::ST_WAIT))
    else $error("accepted sample did not start a computation");

  a_history_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cell_ctrl.clear) |-> (samp_w[Taps-1] == '0 && samp_w[0] == '0))
    else $error("sample history not cleared at end of signal");
`endif

endmodule

// ===== bench/flc_checker.sv =====
// Scoreboard for the full linear convolution block: tracks the tap table, the sample history
// and tap_count from the observed beats, and compares every output beat in order.
// Depends on flc_pkg for widths and the action codes.
`timescale 1ns / 1ps

module flc_checker
  import flc_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  input  logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata,
  input  logic                       s_axis_tuser,
  input  logic                       s_axis_tlast,
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata,
  input  logic                       m_axis_tlast,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_o,
  input  logic [TAP_COUNT_WIDTH-1:0] cfg_data_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [RESULT_WIDTH-1:0] sum;
    logic                    last;
  } conv_beat_t;

  conv_beat_t                     expected_beats[$];
  logic signed [SAMPLE_WIDTH-1:0] kernel[MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] history[MAX_TAPS-1];
  logic [TAP_COUNT_WIDTH-1:0]     tap_count_q;

  // A count of zero still means one tap; anything above the table size is clipped.
  function automatic int active_taps();
    if (tap_count_q == 0) return 1;
    if (tap_count_q > MAX_TAPS) return MAX_TAPS;
    return int'(tap_count_q);
  endfunction

  // Sums the taps in use against the new sample and the history, then shifts it in.
  function automatic logic [RESULT_WIDTH-1:0] shift_and_sum(
    input logic signed [SAMPLE_WIDTH-1:0] x,
    input int                             taps
  );
    longint acc;
    acc = longint'(kernel[0]) * longint'(x);
    for (int k = 1; k < taps; k++) acc += longint'(kernel[k]) * longint'(history[k-1]);
    for (int k = MAX_TAPS - 2; k > 0; k--) history[k] = history[k-1];
    history[0] = x;
    return acc[RESULT_WIDTH-1:0];
  endfunction

  task automatic note_failure(input string msg);
    fail_count_o++;
    if (fail_count_o <= MAX_REPORTS) $display("%0t ns flc_checker: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    conv_beat_t                     want;
    logic [RESULT_WIDTH-1:0]        got_sum;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    int                             taps;
    if (!rst_ni) begin
      foreach (kernel[i]) kernel[i] = '0;
      foreach (history[i]) history[i] = '0;
      tap_count_q = 1;
      expected_beats.delete();
    end else begin
      // Outputs are checked before this edge's input is predicted: a result never leaves
      // in the cycle its sample arrives.
      if (m_axis_tvalid && m_axis_tready) begin
        got_sum = m_axis_tdata[RESULT_WIDTH-1:0];
        if (expected_beats.size() == 0) begin
          note_failure($sformatf("unexpected beat sum=%0d last=%0b",
                                 $signed(got_sum), m_axis_tlast));
        end else begin
          want = expected_beats.pop_front();
          if (got_sum !== want.sum || m_axis_tlast !== want.last)
            note_failure($sformatf("beat mismatch: expected sum=%0d last=%0b, got sum=%0d last=%0b",
                                   $signed(want.sum), want.last, $signed(got_sum), m_axis_tlast));
        end
      end
      if (cfg_valid_i && cfg_ready_o) tap_count_q = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        sample = s_axis_tdata[TAP_INDEX_WIDTH +: SAMPLE_WIDTH];
        if (s_axis_tuser == ACT_LOAD) begin
          // The 4-bit index cannot leave the 16-entry table, so every load lands.
          kernel[s_axis_tdata[TAP_INDEX_WIDTH-1:0]] = sample;
        end else begin
          taps = active_taps();
          want.sum  = shift_and_sum(sample, taps);
          want.last = s_axis_tlast && taps == 1;
          expected_beats.push_back(want);
          if (s_axis_tlast) begin
            for (int t = 1; t < taps; t++) begin
              want.sum  = shift_and_sum('0, taps);
              want.last = (t == taps - 1);
              expected_beats.push_back(want);
            end
            foreach (history[i]) history[i] = '0;
          end
        end
      end
    end
    pending_o = expected_beats.size();
  end

endmodule

// ===== bench/tb_full_linear_convolution.sv =====
// Top of the full linear convolution bench: clock, reset, stimulus and the final verdict.
// Depends on flc_pkg, the block under test and flc_checker, which does all the checking.
`timescale 1ns / 1ps

module tb_full_linear_convolution;
  import flc_pkg::*;

  // Length of the one long receiver hold-off, in cycles.
  localparam int     HOLD_CYCLES   = 300;
  // Cycles allowed for a trailing tap load, or a late stray beat, to settle.
  localparam int     SETTLE_CYCLES = 16;
  // Far beyond the slowest correct run: even 16 beats per item, each behind a long stall,
  // stays well under this.
  localparam longint TIMEOUT_NS    = 64'd10_000_000;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata;   // {pad, value[15:0], tap_index[3:0]}
  logic                       s_axis_tuser;   // action
  logic                       s_axis_tlast;   // last_sample
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;
  logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata;   // {pad, result[35:0]}
  logic                       m_axis_tlast;   // last_result
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [TAP_COUNT_WIDTH-1:0] cfg_data_i;

  int   fail_count;
  int   pending;
  // Idle and stall chances in percent, set per phase by the stimulus.
  int   send_idle_pct;
  int   recv_stall_pct;
  // The stimulus asks for the long hold-off; the receiver marks it served.
  logic hold_request;
  logic hold_served;

  full_linear_convolution dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  flc_checker scoreboard (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver. It changes tready only at falling edges. Once asked, it holds off for a
  // long stretch so that the output register and the pipeline fill up and the block
  // has to push back on its input.
  initial begin
    m_axis_tready = 1'b0;
    hold_served   = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAIL full_linear_convolution");
    $finish;
  end

  // Extremes show up often enough to hit the largest sums.
  function automatic logic [SAMPLE_WIDTH-1:0] random_value();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return SAMPLE_WIDTH'($urandom());
    endcase
  endfunction

  // Offers one beat on the slave stream, with random idle cycles in front of it, and
  // returns at the falling edge after it was taken. The caller starts at a falling edge.
  task automatic push_beat(
    input flc_action_e                act,
    input logic [TAP_INDEX_WIDTH-1:0] idx,
    input logic [SAMPLE_WIDTH-1:0]    val,
    input logic                       lst
  );
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tlast  <= lst;
    s_axis_tdata  <= {{(IN_TDATA_WIDTH - TAP_INDEX_WIDTH - SAMPLE_WIDTH){1'b0}}, val, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // tap_count may only change while the block is idle: every expected beat must have
  // left, and the bench then waits out a settle time for a trailing tap load.
  task automatic set_tap_count(input logic [TAP_COUNT_WIDTH-1:0] count);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= count;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One random phase: a tap count picked with weight on the edge values, then signals of
  // random length with a few tap reloads in between. Now and then the last signal stays
  // open, so the next phase continues it under a new tap count.
  task automatic run_phase(input int idle_s, input int stall_r, input int n_items);
    int                         sent;
    int                         len;
    logic                       leave_open;
    logic [TAP_COUNT_WIDTH-1:0] count_sel;
    case ($urandom_range(5))
      0:       count_sel = '0;
      1:       count_sel = 1;
      2:       count_sel = TAP_COUNT_WIDTH'(MAX_TAPS);
      3:       count_sel = '1;
      default: count_sel = TAP_COUNT_WIDTH'($urandom_range(MAX_TAPS, 1));
    endcase
    set_tap_count(count_sel);
    send_idle_pct  = idle_s;
    recv_stall_pct = stall_r;
    leave_open     = ($urandom_range(3) == 0);
    sent           = 0;
    while (sent < n_items) begin
      len = $urandom_range(12, 1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9) == 0) begin
          push_beat(ACT_LOAD, TAP_INDEX_WIDTH'($urandom_range(15)), random_value(),
                    1'($urandom_range(1)));
          sent++;
        end
        push_beat(ACT_SAMPLE, TAP_INDEX_WIDTH'($urandom_range(15)), random_value(),
                  (i == len - 1) && !(leave_open && sent + 1 >= n_items));
        sent++;
      end
    end
  endtask

  initial begin
    logic [SAMPLE_WIDTH-1:0] tap_val;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = ACT_LOAD;
    s_axis_tlast   = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    hold_request   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. Every tap is written before any sample, so no sum ever reads an
    // unwritten entry of the table. The load's last flag is set on some loads; it must
    // be ignored.
    set_tap_count(TAP_COUNT_WIDTH'(MAX_TAPS));
    for (int k = 0; k < MAX_TAPS; k++) begin
      case (k)
        0:       tap_val = 16'h7FFF;
        1:       tap_val = 16'h8000;
        2:       tap_val = 16'h0000;
        3:       tap_val = 16'h0001;
        4:       tap_val = 16'hFFFF;
        default: tap_val = random_value();
      endcase
      push_beat(ACT_LOAD, TAP_INDEX_WIDTH'(k), tap_val, k[0]);
    end
    // Full-scale samples through all 16 taps, then the 15 tail beats.
    push_beat(ACT_SAMPLE, 4'h0, 16'h7FFF, 1'b0);
    push_beat(ACT_SAMPLE, 4'hF, 16'h8000, 1'b0);
    push_beat(ACT_SAMPLE, 4'h0, 16'h0000, 1'b0);
    push_beat(ACT_SAMPLE, 4'hF, 16'h8000, 1'b1);
    // A count of zero acts as one tap: the single beat carries tlast.
    set_tap_count('0);
    push_beat(ACT_SAMPLE, 4'h5, 16'h8000, 1'b1);
    // An oversized count saturates to the table size; this signal is left open.
    set_tap_count('1);
    push_beat(ACT_SAMPLE, 4'hA, 16'h7FFF, 1'b0);
    // Shrinking the count mid-signal keeps the history; the tail uses the new count.
    set_tap_count(3);
    push_beat(ACT_SAMPLE, 4'h3, 16'h4000, 1'b1);

    // Random part, cycling through the idle and stall mixes.
    for (int p = 0; p < 14; p++) begin
      case (p % 4)
        0:       run_phase(0, 0, 25);
        1:       run_phase(69, 0, 25);
        2:       run_phase(0, 69, 25);
        default: run_phase(17, 17, 25);
      endcase
      // Back-pressure phase: the sender never idles while the receiver holds off, so
      // the block has to stall its input. Full tap count for the longest tails.
      if (p == 6) begin
        set_tap_count(TAP_COUNT_WIDTH'(MAX_TAPS));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b1;
        for (int i = 0; i < 40; i++)
          push_beat(ACT_SAMPLE, TAP_INDEX_WIDTH'($urandom_range(15)), random_value(),
                    (i % 20) == 19);
        hold_request = 1'b0;
      end
    end

    // Close the last signal in case its phase left it open, then drain.
    push_beat(ACT_SAMPLE, 4'h0, random_value(), 1'b1);
    s_axis_tvalid <= 1'b0;
    recv_stall_pct = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (2 * SETTLE_CYCLES) @(negedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("PASS full_linear_convolution");
    end else begin
      $display("FAIL full_linear_convolution");
    end
    $finish;
  end

endmodule

// ===== full_linear_convolution.f =====
rtl/flc_pkg.sv
rtl/flc_cell.sv
rtl/flc_sum_tree.sv
rtl/full_linear_convolution.sv
bench/flc_checker.sv
bench/tb_full_linear_convolution.sv
